@@ rtl/core/rhm61_pkg.sv @@
// ----------------------------------------------------------------------------
// rhm61_pkg
// shared constants and types for the mod 2^61-1 rolling hash core
// ----------------------------------------------------------------------------
package rhm61_pkg;

	localparam int MAX_LEN = 1024;
	localparam int ADDR_W  = $clog2(MAX_LEN);
	localparam int LEN_W   = ADDR_W + 1;
	localparam int HASH_W  = 61;
	localparam int SYM_W   = 8;

	typedef logic [HASH_W-1:0] hash_t;
	typedef logic [ADDR_W-1:0] addr_t;
	typedef logic [LEN_W-1:0]  len_t;

	// mersenne prime 2^61-1
	localparam hash_t MERSENNE_P = {HASH_W{1'b1}};
	localparam hash_t BASE_RESET = hash_t'(131);

	// action codes
	localparam logic [1:0] ACT_START  = 2'd0;
	localparam logic [1:0] ACT_APPEND = 2'd1;
	localparam logic [1:0] ACT_QUERY  = 2'd2;

	// status codes
	localparam logic [1:0] STATUS_OK        = 2'd0;
	localparam logic [1:0] STATUS_BAD_RANGE = 2'd1;
	localparam logic [1:0] STATUS_FULL      = 2'd2;

endpackage

@@ rtl/core/rhm61_mulmod.sv @@
// ----------------------------------------------------------------------------
// rhm61_mulmod
// iterative x*y mod 2^61-1, one 31x31 partial product per cycle
// ----------------------------------------------------------------------------
module rhm61_mulmod import rhm61_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  start,
	input  hash_t x,
	input  hash_t y,
	output logic  done,
	output hash_t result
);

	localparam int LO_W = 30;
	localparam int HI_W = HASH_W - LO_W;
	localparam int PP_W = 2 * HI_W;

	// partial product kinds, selected by the step counter bits
	localparam logic [1:0] KIND_LL = 2'd0;
	localparam logic [1:0] KIND_LH = 2'd1;
	localparam logic [1:0] KIND_HL = 2'd2;
	localparam logic [1:0] KIND_HH = 2'd3;

	localparam logic [2:0] STEP_LAST_PP = 3'd3;
	localparam logic [2:0] STEP_FINAL   = 3'd5;

	logic            active_q;
	logic [2:0]      step_q;
	logic            pvalid_s1;
	logic            done_q;
	hash_t           x_q;
	hash_t           y_q;
	logic [PP_W-1:0] prod_s1;
	logic [1:0]      kind_s1;
	logic [61:0]     acc_q;
	hash_t           result_q;

	logic [HI_W-1:0] op_a;
	logic [HI_W-1:0] op_b;
	logic [62:0]     contrib;
	logic [63:0]     sum;
	logic [61:0]     folded;
	logic [61:0]     fin;
	hash_t           fin_red;

	always_comb begin
		op_a = step_q[1] ? x_q[HASH_W-1:LO_W] : {1'b0, x_q[LO_W-1:0]};
		op_b = step_q[0] ? y_q[HASH_W-1:LO_W] : {1'b0, y_q[LO_W-1:0]};
	end

	// weight of each partial product folded back below 2^62
	always_comb begin
		case (kind_s1)
			KIND_LL: contrib = 63'(prod_s1);
			KIND_LH,
			KIND_HL: contrib = 63'(prod_s1[PP_W-1:31]) + 63'({prod_s1[30:0], 30'b0});
			KIND_HH: contrib = 63'(prod_s1[PP_W-1:1]) + 63'({prod_s1[0], 60'b0});
			default: contrib = '0;
		endcase
		sum     = 64'(acc_q) + 64'(contrib);
		folded  = 62'(sum[HASH_W-1:0]) + 62'(sum[63:HASH_W]);
		fin     = 62'(acc_q[HASH_W-1:0]) + 62'(acc_q[61]);
		fin_red = (fin >= 62'(MERSENNE_P)) ? hash_t'(fin - 62'(MERSENNE_P))
		                                   : fin[HASH_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q  <= 1'b0;
			step_q    <= '0;
			pvalid_s1 <= 1'b0;
			done_q    <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start && !active_q) begin
				active_q  <= 1'b1;
				step_q    <= '0;
				pvalid_s1 <= 1'b0;
			end else if (active_q) begin
				pvalid_s1 <= (step_q <= STEP_LAST_PP);
				step_q    <= step_q + 3'd1;
				if (step_q == STEP_FINAL) begin
					active_q <= 1'b0;
					done_q   <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start && !active_q) begin
			x_q   <= x;
			y_q   <= y;
			acc_q <= '0;
		end else if (active_q) begin
			if (step_q <= STEP_LAST_PP) begin
				prod_s1 <= PP_W'(op_a) * PP_W'(op_b);
				kind_s1 <= step_q[1:0];
			end
			if (pvalid_s1) begin
				acc_q <= folded;
			end
			if (step_q == STEP_FINAL) begin
				result_q <= fin_red;
			end
		end
	end

	assign done   = done_q;
	assign result = result_q;

endmodule

@@ rtl/core/rolling_hash_mersenne61_core.sv @@
// ----------------------------------------------------------------------------
// rolling_hash_mersenne61_core
// polynomial rolling hash mod 2^61-1 over a stored byte string
// ----------------------------------------------------------------------------
// Each input beat carries one action. Start empties the string and answers
// hash 0. Append stores the new prefix hash (prev*base+byte mod p) and the
// next base power, and answers the prefix hash; with 1024 bytes stored it
// answers status 2 and changes nothing. Query answers the hash of bytes
// first_index..last_index, or status 1 if the range is reversed or reaches
// past the stored length. One item is in flight at a time; in_ready is high
// only while the sequencer is idle. All modular products go through one
// shared multiplier that forms one 31x31 partial product per cycle. An append
// with a non-empty string takes two products, a query with first_index above
// 0 one, and a query from index 0, start, first append, errors and the unused
// action code 3 none. The result sits in an output register, so the next
// item is taken while a result still waits for out_ready. Hash base is to
// be written by the user on the cfg port (always ready) only while the block
// is idle; the block itself does not enforce this. The value p is treated as
// base 0. The prefix and power stores are plain memories with no reset; only
// entries below the stored length are ever read.
// ----------------------------------------------------------------------------
module rolling_hash_mersenne61_core import rhm61_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	// configuration
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  hash_t             cfg_data,
	// input beats
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [1:0]        action,
	input  logic [SYM_W-1:0]  symbol,
	input  addr_t             first_index,
	input  addr_t             last_index,
	// result beats
	output logic              out_valid,
	input  logic              out_ready,
	output hash_t             hash_value,
	output logic [1:0]        status
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_LOAD,
		ST_MUL_HASH,
		ST_MUL_POW,
		ST_MUL_QUERY,
		ST_FINISH
	} state_t;

	state_t             state_q;
	len_t               len_q;
	hash_t              base_q;
	logic [1:0]         action_q;
	logic [SYM_W-1:0]   sym_q;
	addr_t              first_q;
	addr_t              last_q;
	hash_t              res_hash_q;
	logic [1:0]         res_status_q;
	logic               out_valid_q;
	hash_t              hash_value_q;
	logic [1:0]         status_q;

	// prefix hash and base power stores
	hash_t              ph_mem [MAX_LEN];
	hash_t              bp_mem [MAX_LEN];
	hash_t              ph_rdata_q;
	hash_t              bp_rdata_q;

	logic               in_fire;
	logic               full;
	logic               empty;
	logic               range_bad;
	logic               app_first;
	logic               app_mul;
	logic               qry_ok;
	logic               ph_re;
	logic               bp_re;
	addr_t              ph_raddr;
	addr_t              bp_raddr;
	logic               ph_we;
	logic               bp_we;
	hash_t              ph_wdata;
	hash_t              bp_wdata;

	logic               mul_start;
	hash_t              mul_x;
	hash_t              mul_y;
	logic               mul_done;
	hash_t              mul_result;

	logic [HASH_W:0]    hv_sum;
	hash_t              hv_app;
	hash_t              hv_query;

	assign cfg_ready = 1'b1;
	assign in_ready  = (state_q == ST_IDLE);
	assign in_fire   = in_valid && in_ready;

	// input beat classification
	always_comb begin
		full      = (len_q == LEN_W'(MAX_LEN));
		empty     = (len_q == '0);
		range_bad = (first_index > last_index) || (LEN_W'(last_index) >= len_q);
		app_first = in_fire && (action == ACT_APPEND) && !full && empty;
		app_mul   = in_fire && (action == ACT_APPEND) && !full && !empty;
		qry_ok    = in_fire && (action == ACT_QUERY) && !range_bad;
	end

	// store read side: previous entry for append, both operands for query
	always_comb begin
		ph_re    = app_mul || qry_ok || (state_q == ST_LOAD && action_q == ACT_QUERY);
		bp_re    = app_mul || (qry_ok && first_index != '0);
		ph_raddr = len_q[ADDR_W-1:0] - addr_t'(1);
		bp_raddr = len_q[ADDR_W-1:0] - addr_t'(1);
		if (state_q == ST_LOAD) begin
			ph_raddr = last_q;
		end else if (qry_ok) begin
			ph_raddr = (first_index == '0) ? last_index : first_index - addr_t'(1);
			bp_raddr = last_index - first_index + addr_t'(1);
		end
	end

	// append result and substring difference
	always_comb begin
		hv_sum   = {1'b0, mul_result} + (HASH_W + 1)'(sym_q);
		hv_app   = (hv_sum >= {1'b0, MERSENNE_P}) ? hash_t'(hv_sum - {1'b0, MERSENNE_P})
		                                          : hv_sum[HASH_W-1:0];
		hv_query = (ph_rdata_q >= mul_result) ? ph_rdata_q - mul_result
		                                      : ph_rdata_q + MERSENNE_P - mul_result;
	end

	// store write side: entry at the current length
	always_comb begin
		ph_we    = app_first || (state_q == ST_MUL_HASH && mul_done);
		bp_we    = app_first || (state_q == ST_MUL_POW && mul_done);
		ph_wdata = (state_q == ST_IDLE) ? hash_t'(symbol) : hv_app;
		bp_wdata = (state_q == ST_IDLE) ? hash_t'(1) : mul_result;
	end

	// shared multiplier operands
	always_comb begin
		mul_start = (state_q == ST_LOAD && action_q == ACT_APPEND)
		         || (state_q == ST_LOAD && action_q == ACT_QUERY && first_q != '0)
		         || (state_q == ST_MUL_HASH && mul_done);
		mul_x     = (state_q == ST_LOAD) ? ph_rdata_q : bp_rdata_q;
		mul_y     = (state_q == ST_LOAD && action_q == ACT_QUERY) ? bp_rdata_q : base_q;
	end

	always_ff @(posedge clk) begin
		if (ph_we) begin
			ph_mem[len_q[ADDR_W-1:0]] <= ph_wdata;
		end
		if (ph_re) begin
			ph_rdata_q <= ph_mem[ph_raddr];
		end
	end

	always_ff @(posedge clk) begin
		if (bp_we) begin
			bp_mem[len_q[ADDR_W-1:0]] <= bp_wdata;
		end
		if (bp_re) begin
			bp_rdata_q <= bp_mem[bp_raddr];
		end
	end

	rhm61_mulmod u_mulmod (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mul_start),
		.x      (mul_x),
		.y      (mul_y),
		.done   (mul_done),
		.result (mul_result)
	);

	// base register, p itself folds to zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q <= BASE_RESET;
		end else if (cfg_valid && cfg_ready) begin
			base_q <= (cfg_data == MERSENNE_P) ? '0 : cfg_data;
		end
	end

	// sequencer and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			len_q        <= '0;
			action_q     <= ACT_START;
			sym_q        <= '0;
			first_q      <= '0;
			last_q       <= '0;
			res_hash_q   <= '0;
			res_status_q <= STATUS_OK;
			out_valid_q  <= 1'b0;
			hash_value_q <= '0;
			status_q     <= STATUS_OK;
		end else begin
			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_fire) begin
						action_q     <= action;
						sym_q        <= symbol;
						first_q      <= first_index;
						last_q       <= last_index;
						res_hash_q   <= '0;
						res_status_q <= STATUS_OK;
						state_q      <= ST_FINISH;
						case (action)
							ACT_START: begin
								len_q <= '0;
							end
							ACT_APPEND: begin
								if (full) begin
									res_status_q <= STATUS_FULL;
								end else if (empty) begin
									len_q      <= len_t'(1);
									res_hash_q <= hash_t'(symbol);
								end else begin
									state_q <= ST_LOAD;
								end
							end
							ACT_QUERY: begin
								if (range_bad) begin
									res_status_q <= STATUS_BAD_RANGE;
								end else begin
									state_q <= ST_LOAD;
								end
							end
							default: begin
								res_status_q <= STATUS_OK;
							end
						endcase
					end
				end
				ST_LOAD: begin
					if (action_q == ACT_APPEND) begin
						state_q <= ST_MUL_HASH;
					end else if (first_q == '0) begin
						res_hash_q <= ph_rdata_q;
						state_q    <= ST_FINISH;
					end else begin
						state_q <= ST_MUL_QUERY;
					end
				end
				ST_MUL_HASH: begin
					if (mul_done) begin
						res_hash_q <= hv_app;
						state_q    <= ST_MUL_POW;
					end
				end
				ST_MUL_POW: begin
					if (mul_done) begin
						len_q   <= len_q + len_t'(1);
						state_q <= ST_FINISH;
					end
				end
				ST_MUL_QUERY: begin
					if (mul_done) begin
						res_hash_q <= hv_query;
						state_q    <= ST_FINISH;
					end
				end
				ST_FINISH: begin
					if (!out_valid_q || out_ready) begin
						out_valid_q  <= 1'b1;
						hash_value_q <= res_hash_q;
						status_q     <= res_status_q;
						state_q      <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign out_valid  = out_valid_q;
	assign hash_value = hash_value_q;
	assign status     = status_q;

endmodule

@@ rtl/core/rhm61_checker.sv @@
// ----------------------------------------------------------------------------
// rhm61_checker
// port-level checks for the rolling hash core, bound to the top level
// ----------------------------------------------------------------------------
module rhm61_checker import rhm61_pkg::*; (
	input logic             clk,
	input logic             arst_n,
	input logic             in_valid,
	input logic             in_ready,
	input logic             out_valid,
	input logic             out_ready,
	input hash_t            hash_value,
	input logic [1:0]       status
);

	// an error beat never carries a hash
	a_error_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status == STATUS_BAD_RANGE || status == STATUS_FULL)
		|-> hash_value == '0)
		else $error("error beat with nonzero hash");

	// every hash is reduced below p
	a_hash_reduced: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> hash_value != MERSENNE_P)
		else $error("hash not reduced mod p");

	// one item at a time: busy right after an accepted beat
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input accepted back to back");

	// a stalled result beat holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(hash_value) && $stable(status))
		else $error("result beat changed while stalled");

endmodule

bind rolling_hash_mersenne61_core rhm61_checker u_rhm61_checker (.*);
